@@ hdl/acps_pkg.sv @@
// Shared types and constants for the anti-aliased capsule pixel shader.
package acps_pkg;

  // Fixed point: 8 fractional bits, pixel centre at half a pixel
  localparam int FRAC_BITS = 8;
  localparam logic [7:0] PIX_HALF = 8'h80;
  localparam logic [8:0] ALPHA_FULL = 9'd256;
  localparam logic [7:0] NEWTON_GUARD = 8'd200;

  // Configuration register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OFFSET = 3'd2;
  localparam logic [2:0] REG_STRIDE = 3'd3;
  localparam logic [2:0] REG_RED    = 3'd4;
  localparam logic [2:0] REG_GREEN  = 3'd5;
  localparam logic [2:0] REG_BLUE   = 3'd6;
  localparam logic [2:0] REG_SPARE  = 3'd7;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic geom;
    logic square;
    logic flat;
    logic root_init;
    logic div_start;
    logic update;
    logic shade;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic outside;
    logic middle;
    logic v_zero;
    logic div_done;
    logic converged;
  } status_t;

endpackage

@@ hdl/acps_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module acps_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        running;
  logic [5:0]  count;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh   = {rem, quotient[31]};
    rem_diff = rem_sh - {1'b0, dvs};
  end

  // Control: run for 32 steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= 6'd0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= 6'd32;
      end else if (running) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= 32'd0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (running) begin
      if (!rem_diff[32]) begin
        rem      <= rem_diff[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= rem_sh[31:0];
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/acps_datapath.sv @@
// Datapath: configuration, geometry, Newton square root and colour blend.
module acps_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic [11:0]       pixel_column,
  input  logic [7:0]        pixel_row,
  input  logic [7:0]        back_red,
  input  logic [7:0]        back_green,
  input  logic [7:0]        back_blue,
  input  acps_pkg::cmd_t    cmd,
  output acps_pkg::status_t status,
  output logic              write_pixel,
  output logic [19:0]       pixel_address,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_spare
);

  // Configuration registers
  logic [11:0] shape_width;
  logic [7:0]  shape_height;
  logic [10:0] column_offset;
  logic [12:0] row_stride;
  logic [7:0]  fill_red, fill_green, fill_blue, fill_spare;

  // Captured transaction
  logic [11:0] x;
  logic [7:0]  y;
  logic [7:0]  br, bg, bb;

  // Geometry results
  logic        outside, middle;
  logic [19:0] addr;
  logic [14:0] r_out;
  logic [15:0] adx, ady;

  // Root state
  logic [31:0] v;
  logic [31:0] est, prev;
  logic [7:0]  guard;

  logic [11:0] w;
  logic [12:0] stride;
  logic [12:0] wo;
  logic [21:0] cx1, cx2, fx;
  logic [15:0] fy;
  logic [20:0] row_base;
  logic        box_out;
  logic [31:0] dx_sq, dy_sq;
  logic [23:0] dsq;
  logic        div_done;
  logic [31:0] q;
  logic [32:0] est_sum;
  logic [31:0] est_next;
  logic        far_apart;
  logic [32:0] dist_in;
  logic        inner, outer;
  logic [8:0]  alpha, alpha_inv;
  logic [16:0] mix_r, mix_g, mix_b;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_width   <= 12'd32;
      shape_height  <= 8'd32;
      column_offset <= 11'd0;
      row_stride    <= 13'd0;
      fill_red      <= 8'd255;
      fill_green    <= 8'd255;
      fill_blue     <= 8'd255;
      fill_spare    <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        acps_pkg::REG_WIDTH:  shape_width   <= cfg_data[11:0];
        acps_pkg::REG_HEIGHT: shape_height  <= cfg_data[7:0];
        acps_pkg::REG_OFFSET: column_offset <= cfg_data[10:0];
        acps_pkg::REG_STRIDE: row_stride    <= cfg_data;
        acps_pkg::REG_RED:    fill_red      <= cfg_data[7:0];
        acps_pkg::REG_GREEN:  fill_green    <= cfg_data[7:0];
        acps_pkg::REG_BLUE:   fill_blue     <= cfg_data[7:0];
        acps_pkg::REG_SPARE:  fill_spare    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Derive box test, row base, end centres and pixel centre
  always_comb begin
    w        = (shape_width < {4'd0, shape_height}) ? {4'd0, shape_height} : shape_width;
    stride   = (row_stride == 13'd0) ? {1'b0, w} : row_stride;
    wo       = {1'b0, w} + {2'b0, column_offset};
    box_out  = (y >= shape_height) || ({1'b0, x} < {2'b0, column_offset}) ||
               ({1'b0, x} >= wo);
    row_base = y * stride;
    cx1      = {3'd0, column_offset, 8'd0} + {7'd0, shape_height, 7'd0};
    cx2      = {1'b0, wo, 8'd0} - {7'd0, shape_height, 7'd0};
    fx       = {2'd0, x, acps_pkg::PIX_HALF};
    fy       = {y, acps_pkg::PIX_HALF};
  end

  // Capture the transaction and register geometry and distances
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x  <= pixel_column;
      y  <= pixel_row;
      br <= back_red;
      bg <= back_green;
      bb <= back_blue;
    end
    if (cmd.geom) begin
      outside <= box_out;
      middle  <= (fx > cx1) && (fx < cx2);
      addr    <= row_base[19:0] + {8'd0, x};
      r_out   <= {shape_height, 7'd0};
      adx     <= (fx <= cx1) ? 16'(cx1 - fx) : 16'(fx - cx2);
      ady     <= (fy >= {1'b0, shape_height, 7'd0}) ? (fy - {1'b0, shape_height, 7'd0})
                                                      : ({1'b0, shape_height, 7'd0} - fy);
    end
  end

  // Square the distance components
  always_comb begin
    dx_sq = adx * adx;
    dy_sq = ady * ady;
    dsq   = dx_sq[31:8] + dy_sq[31:8];
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      v <= {dsq, 8'd0};
    end
  end

  // Serial divider for the Newton step
  acps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (v),
    .divisor  (est),
    .done     (div_done),
    .quotient (q)
  );

  // Newton update and stop rule
  always_comb begin
    est_sum   = {1'b0, est} + {1'b0, q};
    est_next  = est_sum[32:1];
    far_apart = ({1'b0, prev} > {1'b0, est} + 33'd1) ||
                ({1'b0, est} > {1'b0, prev} + 33'd1);
  end

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      est   <= v;
      guard <= 8'd0;
    end else if (cmd.update) begin
      prev  <= est;
      est   <= est_next;
      guard <= guard + 8'd1;
    end
  end

  // Classify distance and blend edge pixels
  always_comb begin
    dist_in   = {1'b0, est} + 33'd256;
    inner     = dist_in <= {18'd0, r_out};
    outer     = {1'b0, est} >= {18'd0, r_out};
    alpha     = 9'(dist_in - {18'd0, r_out});
    alpha_inv = acps_pkg::ALPHA_FULL - alpha;
    mix_r     = br * alpha + fill_red   * alpha_inv;
    mix_g     = bg * alpha + fill_green * alpha_inv;
    mix_b     = bb * alpha + fill_blue  * alpha_inv;
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.flat) begin
      write_pixel   <= !outside;
      pixel_address <= outside ? 20'd0 : addr;
      out_red       <= outside ? 8'd0 : fill_red;
      out_green     <= outside ? 8'd0 : fill_green;
      out_blue      <= outside ? 8'd0 : fill_blue;
      out_spare     <= outside ? 8'd0 : fill_spare;
    end else if (cmd.shade) begin
      if (inner) begin
        write_pixel   <= 1'b1;
        pixel_address <= addr;
        out_red       <= fill_red;
        out_green     <= fill_green;
        out_blue      <= fill_blue;
        out_spare     <= fill_spare;
      end else if (outer) begin
        write_pixel   <= 1'b0;
        pixel_address <= 20'd0;
        out_red       <= 8'd0;
        out_green     <= 8'd0;
        out_blue      <= 8'd0;
        out_spare     <= 8'd0;
      end else begin
        write_pixel   <= 1'b1;
        pixel_address <= addr;
        out_red       <= mix_r[15:8];
        out_green     <= mix_g[15:8];
        out_blue      <= mix_b[15:8];
        out_spare     <= 8'd0;
      end
    end
  end

  // Report status
  always_comb begin
    status.outside   = outside;
    status.middle    = middle;
    status.v_zero    = (v == 32'd0);
    status.div_done  = div_done;
    status.converged = !far_apart || (guard >= acps_pkg::NEWTON_GUARD);
  end

endmodule

@@ hdl/acps_ctrl.sv @@
// Controller: sequences one pixel through geometry, then a flat result or root iterations and shading.
module acps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  acps_pkg::status_t status,
  output acps_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_GEOM  = 9'b000000010,
    S_SQR   = 9'b000000100,
    S_RINIT = 9'b000001000,
    S_KICK  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_CHECK = 9'b001000000,
    S_SHADE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_GEOM;
        end
      end
      S_GEOM: begin
        cmd.geom   = 1'b1;
        state_next = S_SQR;
      end
      S_SQR: begin
        if (status.outside || status.middle) begin
          cmd.flat   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.square = 1'b1;
          state_next = S_RINIT;
        end
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        state_next    = status.v_zero ? S_SHADE : S_KICK;
      end
      S_KICK: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.update = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = status.converged ? S_SHADE : S_KICK;
      end
      S_SHADE: begin
        cmd.shade  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

@@ hdl/antialiased_capsule_pixel_shader.sv @@
// Top level of the anti-aliased capsule pixel shader.
//
//   channel  direction  handshake                     payload
//   config   in         cfg_write                     cfg_index, cfg_data
//   pixel    in         start && !busy                pixel_column .. back_blue
//   result   out        done (one-cycle strobe)       write_pixel .. out_spare
//
// One pixel at a time. Box-outside and middle pixels go from geometry straight
// to the flat result; edge pixels run Newton square-root iterations on the
// 32-step serial divider until the estimate settles or the guard reaches 200.
// Synchronous reset returns the configuration registers to their defaults and
// the controller to idle. The receiver cannot stall; busy holds off new pixels.
module antialiased_capsule_pixel_shader (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [11:0] pixel_column,
  input  logic [7:0]  pixel_row,
  input  logic [7:0]  back_red,
  input  logic [7:0]  back_green,
  input  logic [7:0]  back_blue,
  output logic        write_pixel,
  output logic [19:0] pixel_address,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_spare
);

  acps_pkg::cmd_t    cmd;
  acps_pkg::status_t status;

  acps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  acps_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_column  (pixel_column),
    .pixel_row     (pixel_row),
    .back_red      (back_red),
    .back_green    (back_green),
    .back_blue     (back_blue),
    .cmd           (cmd),
    .status        (status),
    .write_pixel   (write_pixel),
    .pixel_address (pixel_address),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_spare     (out_spare)
  );

endmodule

@@ hdl/acps_checker.sv @@
// Port-level checker for the capsule pixel shader, bound to the top level.
module acps_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        write_pixel,
  input logic [19:0] pixel_address,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_spare
);

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result is only shown while busy, and the block frees up right after
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block still busy after result");

  // A pixel that is not written carries an all-zero payload
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    done && !write_pixel |-> pixel_address == 20'd0 && out_red == 8'd0 &&
      out_green == 8'd0 && out_blue == 8'd0 && out_spare == 8'd0)
    else $error("unwritten pixel with nonzero payload");

endmodule

bind antialiased_capsule_pixel_shader acps_checker u_acps_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .write_pixel   (write_pixel),
  .pixel_address (pixel_address),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue),
  .out_spare     (out_spare)
);
